FILE: src/spi_nand_command_sequencer_defines.svh
// Assertion macros shared by the SPI NAND command sequencer modules.
`ifndef SPI_NAND_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_NAND_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on clk with arst_n low masking the check.
`define SNCS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SNCS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sncs_pkg.sv
// Shared types and constants of the SPI NAND command sequencer.
package sncs_pkg;

	// Plane select bit in the column and erase row shift
	localparam int unsigned PLANE_BIT       = 12;
	localparam int unsigned ERASE_ROW_SHIFT = 6;
	// column with plane bit, wide enough for plane bit positions up to 15
	localparam int unsigned COL_W           = 16;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [3:0] PPB_LOG2_RESET = 4'd6;

	// Request codes
	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_PROG   = 2'd1,
		CMD_ERASE  = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	// Result codes
	localparam logic [2:0] RC_OK       = 3'd0;
	localparam logic [2:0] RC_ECC      = 3'd1;
	localparam logic [2:0] RC_PROGFAIL = 3'd2;
	localparam logic [2:0] RC_ERASEFAIL= 3'd3;
	localparam logic [2:0] RC_REJECT   = 3'd4;

	// Payload kinds
	localparam logic [1:0] PK_NONE  = 2'd0;
	localparam logic [1:0] PK_READ  = 2'd1;
	localparam logic [1:0] PK_WRITE = 2'd2;

	// Flash opcodes
	localparam logic [7:0] OP_PAGE_READ  = 8'h13;
	localparam logic [7:0] OP_CACHE_READ = 8'h03;
	localparam logic [7:0] OP_PROG_LOAD  = 8'h02;
	localparam logic [7:0] OP_PROG_EXEC  = 8'h10;
	localparam logic [7:0] OP_ERASE      = 8'hd8;
	localparam logic [7:0] OP_WREN       = 8'h06;
	localparam logic [7:0] OP_GET_FEAT   = 8'h0f;
	localparam logic [7:0] FEAT_STATUS   = 8'hc0;

	// Waits in microseconds
	localparam logic [11:0] DLY_PAGE_READ = 12'd100;
	localparam logic [11:0] DLY_PROG      = 12'd400;
	localparam logic [11:0] DLY_ERASE     = 12'd4000;

	// Work handed from front to back
	typedef enum logic [2:0] {
		K_EVENT    = 3'd0,   // no frame, done flag and code only
		K_POLL     = 3'd1,   // status read again
		K_READ_FIN = 3'd2,   // cache read frame
		K_READ     = 3'd3,
		K_PROG     = 3'd4,
		K_ERASE    = 3'd5
	} job_kind_t;

	typedef struct packed {
		job_kind_t        kind;
		logic [15:0]      row;
		logic [COL_W-1:0] col;
		logic [12:0]      len;
		logic             done;
		logic [2:0]       code;
	} job_t;

endpackage

FILE: src/spi_nand_command_sequencer.sv
// Path: a request is written into the job queue, then its beats pass through the output register.
// Throughput: one result beat per cycle while out_ready is high; a request gives 1 to 4 beats (program gives 4),
// so the back end's one-frame-per-cycle expansion, stalled while out_ready is low, limits the request rate.
// Requests are taken every cycle while the two-entry job queue has room.
// Reset (arst_n low, asynchronous): no pending operation, empty queue, no output beat,
// pages_per_block_log2 = 6, saved read column and length zero.
module spi_nand_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] page,
	input  logic [9:0]  block,
	input  logic [11:0] column,
	input  logic [12:0] length,
	input  logic [7:0]  status_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  opcode,
	output logic [23:0] header_args,
	output logic [2:0]  header_len,
	output logic [1:0]  payload_kind,
	output logic [12:0] payload_len,
	output logic [11:0] delay_us,
	output logic        op_done,
	output logic [2:0]  result_code,
	output logic        last
);

	logic           q_full, push, pop, head_valid;
	sncs_pkg::job_t push_job, head;

	sncs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.page        (page),
		.block       (block),
		.column      (column),
		.length      (length),
		.status_byte (status_byte),
		.q_full      (q_full),
		.push        (push),
		.push_job    (push_job)
	);

	sncs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	sncs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.opcode       (opcode),
		.header_args  (header_args),
		.header_len   (header_len),
		.payload_kind (payload_kind),
		.payload_len  (payload_len),
		.delay_us     (delay_us),
		.op_done      (op_done),
		.result_code  (result_code),
		.last         (last)
	);

endmodule

FILE: src/sncs_front.sv
// Front end: takes requests, tracks the pending operation, builds jobs.
module sncs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [3:0]          cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          command,
	input  logic [15:0]         page,
	input  logic [9:0]          block,
	input  logic [11:0]         column,
	input  logic [12:0]         length,
	input  logic [7:0]          status_byte,
	input  logic                q_full,
	output logic                push,
	output sncs_pkg::job_t      push_job
);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_READ  = 4'b0010,
		PH_PROG  = 4'b0100,
		PH_ERASE = 4'b1000
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic [3:0]                    ppb_log2_q;
	logic [sncs_pkg::COL_W-1:0]    saved_col_q;
	logic [12:0]                   saved_len_q;
	logic [sncs_pkg::COL_W-1:0]    plane_col;
	logic [15:0]                   erase_row;
	logic                          save_en;
	sncs_pkg::cmd_t                cmd;

	assign cmd      = sncs_pkg::cmd_t'(command);
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// column with plane select from block parity
	assign plane_col = sncs_pkg::COL_W'(column)
		| (sncs_pkg::COL_W'(page[ppb_log2_q]) << sncs_pkg::PLANE_BIT);
	assign erase_row = 16'(32'(block) << sncs_pkg::ERASE_ROW_SHIFT);

	// classify the request against the pending operation
	always_comb begin
		phase_d          = phase_q;
		save_en          = 1'b0;
		push_job.kind    = sncs_pkg::K_EVENT;
		push_job.row     = page;
		push_job.col     = plane_col;
		push_job.len     = length;
		push_job.done    = 1'b0;
		push_job.code    = sncs_pkg::RC_REJECT;
		if (cmd == sncs_pkg::CMD_STATUS) begin
			priority if (phase_q == PH_IDLE) begin
				push_job.kind = sncs_pkg::K_EVENT;
			end else if (status_byte[0]) begin
				push_job.kind = sncs_pkg::K_POLL;
			end else if (phase_q == PH_READ) begin
				push_job.kind = sncs_pkg::K_READ_FIN;
				push_job.col  = saved_col_q;
				push_job.len  = saved_len_q;
				push_job.done = 1'b1;
				push_job.code = (status_byte[5:4] == 2'b10) ? sncs_pkg::RC_ECC
					: sncs_pkg::RC_OK;
				phase_d       = PH_IDLE;
			end else if (phase_q == PH_PROG) begin
				push_job.done = 1'b1;
				push_job.code = status_byte[3] ? sncs_pkg::RC_PROGFAIL : sncs_pkg::RC_OK;
				phase_d       = PH_IDLE;
			end else begin
				push_job.done = 1'b1;
				push_job.code = status_byte[2] ? sncs_pkg::RC_ERASEFAIL : sncs_pkg::RC_OK;
				phase_d       = PH_IDLE;
			end
		end else if (phase_q != PH_IDLE) begin
			push_job.kind = sncs_pkg::K_EVENT;
		end else begin
			push_job.code = sncs_pkg::RC_OK;
			unique case (cmd)
				sncs_pkg::CMD_READ: begin
					push_job.kind = sncs_pkg::K_READ;
					save_en       = 1'b1;
					phase_d       = PH_READ;
				end
				sncs_pkg::CMD_PROG: begin
					push_job.kind = sncs_pkg::K_PROG;
					phase_d       = PH_PROG;
				end
				default: begin
					push_job.kind = sncs_pkg::K_ERASE;
					push_job.row  = erase_row;
					phase_d       = PH_ERASE;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			ppb_log2_q  <= sncs_pkg::PPB_LOG2_RESET;
			saved_col_q <= '0;
			saved_len_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				ppb_log2_q <= cfg_wr_data;
			end
			if (push) begin
				phase_q <= phase_d;
				if (save_en) begin
					saved_col_q <= plane_col;
					saved_len_q <= length;
				end
			end
		end
	end

endmodule

FILE: src/sncs_queue.sv
// Small job queue between front and back end.
`include "spi_nand_command_sequencer_defines.svh"
module sncs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sncs_pkg::job_t      push_job,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output sncs_pkg::job_t      head
);

	sncs_pkg::job_t                    entries_q [sncs_pkg::QDEPTH];
	logic [sncs_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [sncs_pkg::QCNT_W-1:0]       count_q;

	assign full       = (count_q == sncs_pkg::QCNT_W'(sncs_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == sncs_pkg::QPTR_W'(sncs_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sncs_pkg::QPTR_W'(sncs_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SNCS_ASSERT_IMP(a_no_overflow, push, !full || pop, "job pushed into full queue")
	`SNCS_ASSERT_IMP(a_no_underflow, pop, head_valid, "job popped from empty queue")

endmodule

FILE: src/sncs_back.sv
// Back end: expands a job into frame beats through an output register.
`include "spi_nand_command_sequencer_defines.svh"
module sncs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  sncs_pkg::job_t      head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          opcode,
	output logic [23:0]         header_args,
	output logic [2:0]          header_len,
	output logic [1:0]          payload_kind,
	output logic [12:0]         payload_len,
	output logic [11:0]         delay_us,
	output logic                op_done,
	output logic [2:0]          result_code,
	output logic                last
);

	logic [1:0]  idx_q;
	logic        load;
	logic        out_valid_q;
	logic [7:0]  opcode_q, b_opcode;
	logic [23:0] args_q, b_args;
	logic [2:0]  hlen_q, b_hlen;
	logic [1:0]  pkind_q, b_pkind;
	logic [12:0] plen_q, b_plen;
	logic [11:0] dly_q, b_dly;
	logic        done_q, b_done;
	logic [2:0]  code_q, b_code;
	logic        last_q, b_last;
	logic [23:0] row_args, col_args;

	assign row_args = 24'(head.row);
	assign col_args = 24'(head.col) << 8;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && b_last;

	// beat contents for the current job and beat index
	always_comb begin
		b_opcode = '0;
		b_args   = '0;
		b_hlen   = '0;
		b_pkind  = sncs_pkg::PK_NONE;
		b_plen   = '0;
		b_dly    = '0;
		b_done   = 1'b0;
		b_code   = sncs_pkg::RC_OK;
		b_last   = 1'b0;
		// status read frame, used by several jobs
		if ((head.kind == sncs_pkg::K_POLL)
			|| (head.kind == sncs_pkg::K_READ && idx_q == 2'd1)
			|| (head.kind == sncs_pkg::K_PROG && idx_q == 2'd3)
			|| (head.kind == sncs_pkg::K_ERASE && idx_q == 2'd2)) begin
			b_opcode = sncs_pkg::OP_GET_FEAT;
			b_args   = {sncs_pkg::FEAT_STATUS, 16'h0000};
			b_hlen   = 3'd2;
			b_pkind  = sncs_pkg::PK_READ;
			b_plen   = 13'd1;
			b_last   = 1'b1;
		end else begin
			unique case (head.kind)
				sncs_pkg::K_EVENT: begin
					b_done = head.done;
					b_code = head.code;
					b_last = 1'b1;
				end
				sncs_pkg::K_READ_FIN: begin
					b_opcode = sncs_pkg::OP_CACHE_READ;
					b_args   = col_args;
					b_hlen   = 3'd4;
					b_pkind  = sncs_pkg::PK_READ;
					b_plen   = head.len;
					b_done   = 1'b1;
					b_code   = head.code;
					b_last   = 1'b1;
				end
				sncs_pkg::K_READ: begin
					b_opcode = sncs_pkg::OP_PAGE_READ;
					b_args   = row_args;
					b_hlen   = 3'd4;
					b_dly    = sncs_pkg::DLY_PAGE_READ;
				end
				sncs_pkg::K_PROG: begin
					unique case (idx_q)
						2'd0: begin
							b_opcode = sncs_pkg::OP_WREN;
							b_hlen   = 3'd1;
						end
						2'd1: begin
							b_opcode = sncs_pkg::OP_PROG_LOAD;
							b_args   = col_args;
							b_hlen   = 3'd3;
							b_pkind  = sncs_pkg::PK_WRITE;
							b_plen   = head.len;
						end
						default: begin
							b_opcode = sncs_pkg::OP_PROG_EXEC;
							b_args   = row_args;
							b_hlen   = 3'd4;
							b_dly    = sncs_pkg::DLY_PROG;
						end
					endcase
				end
				sncs_pkg::K_ERASE: begin
					if (idx_q == 2'd0) begin
						b_opcode = sncs_pkg::OP_WREN;
						b_hlen   = 3'd1;
					end else begin
						b_opcode = sncs_pkg::OP_ERASE;
						b_args   = row_args;
						b_hlen   = 3'd4;
						b_dly    = sncs_pkg::DLY_ERASE;
					end
				end
				default: begin
					b_last = 1'b1;
				end
			endcase
		end
	end

	// beat index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= b_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			opcode_q <= b_opcode;
			args_q   <= b_args;
			hlen_q   <= b_hlen;
			pkind_q  <= b_pkind;
			plen_q   <= b_plen;
			dly_q    <= b_dly;
			done_q   <= b_done;
			code_q   <= b_code;
			last_q   <= b_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign opcode       = opcode_q;
	assign header_args  = args_q;
	assign header_len   = hlen_q;
	assign payload_kind = pkind_q;
	assign payload_len  = plen_q;
	assign delay_us     = dly_q;
	assign op_done      = done_q;
	assign result_code  = code_q;
	assign last         = last_q;

	`SNCS_ASSERT_NXT(a_idx_restart, pop, idx_q == 2'd0, "beat index not cleared after job")
	`SNCS_ASSERT_IMP(a_single_beat_idx,
		head_valid && (head.kind == sncs_pkg::K_EVENT || head.kind == sncs_pkg::K_POLL
		|| head.kind == sncs_pkg::K_READ_FIN), idx_q == 2'd0,
		"single-beat job seen past its first beat")

endmodule
